// File: src/lcdr_pkg.sv
package lcdr_pkg;

	localparam int LINE_LEN_DEF = 20;
	localparam int NUM_LINES = 4;
	localparam int LINE_W = 2;
	localparam int COL_W = 5;
	localparam int BYTE_W = 8;
	localparam int WAIT_W = 9;
	localparam int STEP_W = 6;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_STATUS = 2'd1,
		CMD_INIT = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_RSTART = 2'd1,
		ACT_SEND = 2'd2,
		ACT_STOP = 2'd3
	} act_t;

	localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST = 8'h78;
	localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [BYTE_W-1:0] CTRL_CMD = 8'h80;
	localparam logic [BYTE_W-1:0] CTRL_DATA = 8'h40;
	localparam logic [BYTE_W-1:0] DDRAM_ROW_0 = 8'h80;
	localparam logic [BYTE_W-1:0] DDRAM_ROW_1 = 8'hC0;
	localparam logic [BYTE_W-1:0] LCD_FUNC_SET = 8'h38;
	localparam logic [BYTE_W-1:0] LCD_DISP_ON = 8'h0C;
	localparam logic [BYTE_W-1:0] LCD_CLEAR = 8'h01;

	localparam logic [BYTE_W-1:0] STAT_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] STAT_START = 8'h08;
	localparam logic [BYTE_W-1:0] STAT_RSTART = 8'h10;
	localparam logic [BYTE_W-1:0] STAT_ADDR_ACK = 8'h18;
	localparam logic [BYTE_W-1:0] STAT_DATA_ACK = 8'h28;

	localparam logic [WAIT_W-1:0] WAIT_NONE = 9'd0;
	localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 9'd400;
	localparam logic [WAIT_W-1:0] WAIT_SHORT = 9'd1;
	localparam logic [WAIT_W-1:0] WAIT_CLEAR = 9'd100;

	localparam logic [STEP_W-1:0] STEP_IDLE = 6'd0;
	localparam logic [STEP_W-1:0] STEP_ADDR = 6'd1;
	localparam logic [STEP_W-1:0] STEP_CTRL = 6'd2;
	localparam logic [STEP_W-1:0] STEP_ROW_0 = 6'd3;
	localparam logic [STEP_W-1:0] STEP_DATA = 6'd4;
	localparam logic [STEP_W-1:0] STEP_LINE_0 = 6'd5;
	localparam logic [STEP_W-1:0] STEP_LINE_2 = 6'd6;
	localparam logic [STEP_W-1:0] STEP_RSTART = 6'd7;
	localparam logic [STEP_W-1:0] STEP_ADDR_2 = 6'd8;
	localparam logic [STEP_W-1:0] STEP_CTRL_2 = 6'd9;
	localparam logic [STEP_W-1:0] STEP_ROW_1 = 6'd10;
	localparam logic [STEP_W-1:0] STEP_DATA_2 = 6'd11;
	localparam logic [STEP_W-1:0] STEP_LINE_1 = 6'd12;
	localparam logic [STEP_W-1:0] STEP_LINE_3 = 6'd13;
	localparam logic [STEP_W-1:0] STEP_STOP = 6'd14;
	localparam logic [STEP_W-1:0] STEP_INIT_FIRST = 6'd17;
	localparam logic [STEP_W-1:0] STEP_INIT_LAST = 6'd33;

	typedef struct packed {
		logic two;
		act_t act0;
		logic [BYTE_W-1:0] byte0;
		logic [WAIT_W-1:0] wait0;
		logic [WAIT_W-1:0] wait1;
	} entry_t;

	function automatic logic [BYTE_W-1:0] init_cmd(input logic [1:0] phase);
		logic [BYTE_W-1:0] res;
		case (phase)
			2'd0: res = LCD_FUNC_SET;
			2'd1: res = LCD_DISP_ON;
			default: res = LCD_CLEAR;
		endcase
		return res;
	endfunction

	function automatic logic [WAIT_W-1:0] init_wait(input logic [1:0] phase);
		logic [WAIT_W-1:0] res;
		case (phase)
			2'd0: res = WAIT_POWER_UP;
			2'd3: res = WAIT_CLEAR;
			default: res = WAIT_SHORT;
		endcase
		return res;
	endfunction

endpackage

// File: src/lcdr_if.sv
interface lcdr_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] bus_status;
	logic [1:0] line_select;
	logic [4:0] column;
	logic [7:0] char_code;

	modport source (output valid, cmd, bus_status, line_select, column, char_code,
		input ready);
	modport sink (input valid, cmd, bus_status, line_select, column, char_code,
		output ready);
endinterface

interface lcdr_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [8:0] wait_before;
	logic last;

	modport source (output valid, action, data_byte, wait_before, last, input ready);
	modport sink (input valid, action, data_byte, wait_before, last, output ready);
endinterface

// File: src/i2c_lcd_refresh_sequencer_unit.sv
// The first bus action of a request passes through the stage register, the action queue and
// the output register before it is presented. One request is accepted per cycle while the
// four-entry action queue has room; a request yielding a stop and a start presents both in turn.
// Reset is asynchronous: the sequencer goes idle, the queue empties, the address byte returns
// to 0x78, and per-character flags make the line store read as spaces at once, with no sweep.
module i2c_lcd_refresh_sequencer_unit #(
	parameter int LINE_LEN = lcdr_pkg::LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	lcdr_req_if.sink req,
	lcdr_rsp_if.source rsp
);

	logic [lcdr_pkg::BYTE_W-1:0] slave_addr_q;
	logic q_push;
	logic q_pop;
	lcdr_pkg::entry_t q_entry;
	lcdr_pkg::entry_t q_head;
	logic [lcdr_pkg::Q_CNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= lcdr_pkg::SLAVE_ADDR_RST;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	lcdr_front #(
		.LINE_LEN(LINE_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.slave_addr(slave_addr_q),
		.q_count(q_count),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	lcdr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(q_entry),
		.pop(q_pop),
		.head(q_head),
		.count(q_count)
	);

	lcdr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_head(q_head),
		.q_count(q_count),
		.q_pop(q_pop),
		.rsp(rsp)
	);

endmodule

// File: src/lcdr_ram.sv
module lcdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/lcdr_front.sv
module lcdr_front #(
	parameter int LINE_LEN = lcdr_pkg::LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	lcdr_req_if.sink req,
	input logic [lcdr_pkg::BYTE_W-1:0] slave_addr,
	input logic [lcdr_pkg::Q_CNT_W-1:0] q_count,
	output logic q_push,
	output lcdr_pkg::entry_t q_entry
);

	localparam int STORE_DEPTH = lcdr_pkg::NUM_LINES * LINE_LEN;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int POS_W = $clog2(LINE_LEN);
	localparam logic [1:0] SUB_FRAME = 2'd0;
	localparam logic [1:0] SUB_ADDR = 2'd1;
	localparam logic [1:0] SUB_CTRL = 2'd2;
	localparam logic [1:0] SUB_CMD = 2'd3;

	logic [lcdr_pkg::STEP_W-1:0] seq_step_q;
	logic [POS_W-1:0] char_pos_q;
	logic [STORE_DEPTH-1:0] filled_q;

	logic vld_s1;
	logic char_s1;
	logic filled_s1;
	lcdr_pkg::entry_t entry_s1;

	logic accept;
	lcdr_pkg::cmd_t cmd;
	logic status_ok;
	logic [lcdr_pkg::BYTE_W-1:0] status;
	logic [lcdr_pkg::STEP_W-1:0] init_off;

	logic adv_has;
	logic adv_char;
	logic [lcdr_pkg::LINE_W-1:0] adv_line;
	logic [lcdr_pkg::STEP_W-1:0] adv_step;
	logic [POS_W-1:0] adv_pos;
	lcdr_pkg::entry_t adv_entry;

	logic res_has;
	logic res_char;
	logic [lcdr_pkg::STEP_W-1:0] nxt_step;
	logic [POS_W-1:0] nxt_pos;
	lcdr_pkg::entry_t res_entry;

	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [lcdr_pkg::BYTE_W-1:0] rd_data;

	assign req.ready = (q_count + lcdr_pkg::Q_CNT_W'(vld_s1)) <
		lcdr_pkg::Q_CNT_W'(lcdr_pkg::Q_DEPTH);
	assign accept = req.valid && req.ready;
	assign cmd = lcdr_pkg::cmd_t'(req.cmd);
	assign status = req.bus_status & lcdr_pkg::STAT_MASK;
	assign status_ok = (status == lcdr_pkg::STAT_START) || (status == lcdr_pkg::STAT_RSTART) ||
		(status == lcdr_pkg::STAT_ADDR_ACK) || (status == lcdr_pkg::STAT_DATA_ACK);
	assign init_off = seq_step_q - lcdr_pkg::STEP_INIT_FIRST;

	// One step of the refresh or power-up sequence on an accepted bus status.
	always_comb begin
		adv_has = 1'b0;
		adv_char = 1'b0;
		adv_line = '0;
		adv_step = seq_step_q + 6'd1;
		adv_pos = char_pos_q;
		adv_entry = '{two: 1'b0, act0: lcdr_pkg::ACT_SEND, byte0: '0,
			wait0: lcdr_pkg::WAIT_NONE, wait1: lcdr_pkg::WAIT_NONE};
		unique case (seq_step_q) inside
			lcdr_pkg::STEP_IDLE: begin
				adv_step = lcdr_pkg::STEP_IDLE;
			end
			lcdr_pkg::STEP_ADDR, lcdr_pkg::STEP_ADDR_2: begin
				adv_has = 1'b1;
				adv_entry.byte0 = slave_addr;
			end
			lcdr_pkg::STEP_CTRL, lcdr_pkg::STEP_CTRL_2: begin
				adv_has = 1'b1;
				adv_entry.byte0 = lcdr_pkg::CTRL_CMD;
			end
			lcdr_pkg::STEP_ROW_0: begin
				adv_has = 1'b1;
				adv_entry.byte0 = lcdr_pkg::DDRAM_ROW_0;
			end
			lcdr_pkg::STEP_ROW_1: begin
				adv_has = 1'b1;
				adv_entry.byte0 = lcdr_pkg::DDRAM_ROW_1;
			end
			lcdr_pkg::STEP_DATA: begin
				adv_has = 1'b1;
				adv_entry.byte0 = lcdr_pkg::CTRL_DATA;
			end
			lcdr_pkg::STEP_DATA_2: begin
				adv_has = 1'b1;
				adv_entry.byte0 = lcdr_pkg::CTRL_DATA;
				adv_pos = '0;
			end
			lcdr_pkg::STEP_LINE_0, lcdr_pkg::STEP_LINE_2,
			lcdr_pkg::STEP_LINE_1, lcdr_pkg::STEP_LINE_3: begin
				adv_has = 1'b1;
				adv_char = 1'b1;
				case (seq_step_q)
					lcdr_pkg::STEP_LINE_0: adv_line = 2'd0;
					lcdr_pkg::STEP_LINE_2: adv_line = 2'd2;
					lcdr_pkg::STEP_LINE_1: adv_line = 2'd1;
					default: adv_line = 2'd3;
				endcase
				if (char_pos_q == POS_W'(LINE_LEN - 1)) begin
					adv_pos = '0;
				end else begin
					adv_pos = char_pos_q + POS_W'(1);
					adv_step = seq_step_q;
				end
			end
			lcdr_pkg::STEP_RSTART: begin
				adv_has = 1'b1;
				adv_entry.act0 = lcdr_pkg::ACT_RSTART;
			end
			lcdr_pkg::STEP_STOP: begin
				adv_has = 1'b1;
				adv_entry.act0 = lcdr_pkg::ACT_STOP;
				adv_step = lcdr_pkg::STEP_IDLE;
			end
			[lcdr_pkg::STEP_INIT_FIRST:lcdr_pkg::STEP_INIT_LAST]: begin
				adv_has = 1'b1;
				case (init_off[1:0])
					SUB_FRAME: begin
						if (seq_step_q == lcdr_pkg::STEP_INIT_FIRST) begin
							adv_entry.act0 = lcdr_pkg::ACT_START;
							adv_entry.wait0 = lcdr_pkg::init_wait(2'd0);
						end else if (seq_step_q == lcdr_pkg::STEP_INIT_LAST) begin
							adv_entry.act0 = lcdr_pkg::ACT_STOP;
							adv_step = lcdr_pkg::STEP_IDLE;
						end else begin
							adv_entry.two = 1'b1;
							adv_entry.act0 = lcdr_pkg::ACT_STOP;
							adv_entry.wait1 = lcdr_pkg::init_wait(init_off[3:2]);
						end
					end
					SUB_ADDR: adv_entry.byte0 = slave_addr;
					SUB_CTRL: adv_entry.byte0 = lcdr_pkg::CTRL_CMD;
					SUB_CMD: adv_entry.byte0 = lcdr_pkg::init_cmd(init_off[3:2]);
					default: adv_entry.byte0 = '0;
				endcase
			end
			default: begin
				adv_step = lcdr_pkg::STEP_IDLE;
			end
		endcase
	end

	// Request decode.
	always_comb begin
		res_has = 1'b0;
		res_char = 1'b0;
		nxt_step = seq_step_q;
		nxt_pos = char_pos_q;
		res_entry = adv_entry;
		wr_en = 1'b0;
		unique case (cmd)
			lcdr_pkg::CMD_TICK: begin
				res_has = 1'b1;
				nxt_step = lcdr_pkg::STEP_ADDR;
				nxt_pos = '0;
				res_entry = '{two: 1'b0, act0: lcdr_pkg::ACT_START, byte0: '0,
					wait0: lcdr_pkg::WAIT_NONE, wait1: lcdr_pkg::WAIT_NONE};
			end
			lcdr_pkg::CMD_STATUS: begin
				if (status_ok) begin
					res_has = adv_has;
					res_char = adv_char;
					nxt_step = adv_step;
					nxt_pos = adv_pos;
				end
			end
			lcdr_pkg::CMD_INIT: begin
				res_has = 1'b1;
				nxt_step = lcdr_pkg::STEP_INIT_FIRST + 6'd1;
				nxt_pos = '0;
				res_entry = '{two: 1'b0, act0: lcdr_pkg::ACT_START, byte0: '0,
					wait0: lcdr_pkg::init_wait(2'd0), wait1: lcdr_pkg::WAIT_NONE};
			end
			lcdr_pkg::CMD_WRITE: begin
				wr_en = accept && (32'(req.column) < LINE_LEN);
			end
			default: begin
				res_has = 1'b0;
			end
		endcase
	end

	assign wr_addr = ADDR_W'(req.line_select) * ADDR_W'(LINE_LEN) + ADDR_W'(req.column);
	assign rd_addr = ADDR_W'(adv_line) * ADDR_W'(LINE_LEN) + ADDR_W'(char_pos_q);

	lcdr_ram #(
		.WIDTH(lcdr_pkg::BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(req.char_code),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_step_q <= lcdr_pkg::STEP_IDLE;
			char_pos_q <= '0;
			filled_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && res_has;
			if (accept) begin
				seq_step_q <= nxt_step;
				char_pos_q <= nxt_pos;
			end
			if (wr_en) begin
				filled_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_s1 <= res_entry;
		char_s1 <= res_char;
		filled_s1 <= filled_q[rd_addr];
	end

	// A character that was never written still reads as a space.
	always_comb begin
		q_entry = entry_s1;
		if (char_s1) begin
			q_entry.byte0 = filled_s1 ? rd_data : lcdr_pkg::SPACE_CHAR;
		end
	end

	assign q_push = vld_s1;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(char_pos_q) < LINE_LEN)
		else $error("Character position ran past the line length.");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(req.valid && req.ready))
		else $error("Queue push without an accepted request.");

endmodule

// File: src/lcdr_queue.sv
module lcdr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lcdr_pkg::entry_t din,
	input logic pop,
	output lcdr_pkg::entry_t head,
	output logic [lcdr_pkg::Q_CNT_W-1:0] count
);

	lcdr_pkg::entry_t slot_q [lcdr_pkg::Q_DEPTH];
	logic [lcdr_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [lcdr_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [lcdr_pkg::Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lcdr_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lcdr_pkg::Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + lcdr_pkg::Q_CNT_W'(1);
				2'b01: count_q <= count_q - lcdr_pkg::Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	assign head = slot_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < lcdr_pkg::Q_CNT_W'(lcdr_pkg::Q_DEPTH)) || pop)
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("Queue read while empty.");

endmodule

// File: src/lcdr_back.sv
module lcdr_back (
	input logic clk,
	input logic arst_n,
	input lcdr_pkg::entry_t q_head,
	input logic [lcdr_pkg::Q_CNT_W-1:0] q_count,
	output logic q_pop,
	lcdr_rsp_if.source rsp
);

	lcdr_pkg::entry_t cur_q;
	logic cur_vld_q;
	logic idx_q;
	logic load;

	assign load = !cur_vld_q || (rsp.ready && (idx_q || !cur_q.two));
	assign q_pop = load && (q_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else begin
			if (load) begin
				cur_vld_q <= q_count != '0;
				idx_q <= 1'b0;
			end else if (rsp.ready) begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	assign rsp.valid = cur_vld_q;
	assign rsp.action = idx_q ? lcdr_pkg::ACT_START : cur_q.act0;
	assign rsp.data_byte = idx_q ? '0 : cur_q.byte0;
	assign rsp.wait_before = idx_q ? cur_q.wait1 : cur_q.wait0;
	assign rsp.last = idx_q || !cur_q.two;

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> cur_vld_q && cur_q.two)
		else $error("Second action shown for a single-action entry.");

endmodule

// File: tb/lcdr_action_check.sv
module lcdr_action_check
	import lcdr_pkg::*;
#(
	parameter int LINE_LEN = LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	lcdr_req_if req,
	lcdr_rsp_if rsp,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		act_t act;
		logic [BYTE_W-1:0] data;
		logic [WAIT_W-1:0] dly;
		logic last;
	} bus_op_t;

	localparam logic [4*BYTE_W-1:0] POWER_CMDS = {LCD_CLEAR, LCD_CLEAR, LCD_DISP_ON, LCD_FUNC_SET};
	localparam logic [4*WAIT_W-1:0] POWER_WAITS = {WAIT_CLEAR, WAIT_SHORT, WAIT_SHORT,
		WAIT_POWER_UP};

	bus_op_t ops_due[$];
	bus_op_t want;
	logic [BYTE_W-1:0] addr_byte;
	logic [BYTE_W-1:0] screen [NUM_LINES*LINE_LEN];
	int unsigned step;
	int unsigned char_idx;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic void emit(act_t a, logic [BYTE_W-1:0] d, logic [WAIT_W-1:0] w, logic l);
		bus_op_t op;
		op.act = a;
		op.data = d;
		op.dly = w;
		op.last = l;
		ops_due.push_back(op);
	endfunction

	function automatic void send_char(int unsigned line, int unsigned next_step);
		emit(ACT_SEND, screen[line*LINE_LEN + char_idx], WAIT_NONE, 1'b1);
		if (char_idx + 1 < LINE_LEN) begin
			char_idx = char_idx + 1;
		end else begin
			char_idx = 0;
			step = next_step;
		end
	endfunction

	function automatic void advance_sequence();
		int unsigned phase;
		int unsigned sub;
		if (step >= STEP_INIT_FIRST && step <= STEP_INIT_LAST) begin
			phase = (step - STEP_INIT_FIRST) >> 2;
			sub = (step - STEP_INIT_FIRST) & 3;
			if (sub == 0) begin
				if (step == STEP_INIT_LAST) begin
					emit(ACT_STOP, '0, WAIT_NONE, 1'b1);
					step = STEP_IDLE;
				end else begin
					if (step != STEP_INIT_FIRST)
						emit(ACT_STOP, '0, WAIT_NONE, 1'b0);
					emit(ACT_START, '0, POWER_WAITS[WAIT_W*phase +: WAIT_W], 1'b1);
					step = step + 1;
				end
			end else begin
				case (sub)
					1: emit(ACT_SEND, addr_byte, WAIT_NONE, 1'b1);
					2: emit(ACT_SEND, CTRL_CMD, WAIT_NONE, 1'b1);
					default: emit(ACT_SEND, POWER_CMDS[BYTE_W*phase +: BYTE_W], WAIT_NONE, 1'b1);
				endcase
				step = step + 1;
			end
		end else begin
			case (step)
				STEP_IDLE: ;
				STEP_ADDR, STEP_ADDR_2: begin
					emit(ACT_SEND, addr_byte, WAIT_NONE, 1'b1);
					step = step + 1;
				end
				STEP_CTRL, STEP_CTRL_2: begin
					emit(ACT_SEND, CTRL_CMD, WAIT_NONE, 1'b1);
					step = step + 1;
				end
				STEP_ROW_0: begin
					emit(ACT_SEND, DDRAM_ROW_0, WAIT_NONE, 1'b1);
					step = step + 1;
				end
				STEP_ROW_1: begin
					emit(ACT_SEND, DDRAM_ROW_1, WAIT_NONE, 1'b1);
					step = step + 1;
				end
				STEP_DATA, STEP_DATA_2: begin
					emit(ACT_SEND, CTRL_DATA, WAIT_NONE, 1'b1);
					if (step == STEP_DATA_2)
						char_idx = 0;
					step = step + 1;
				end
				STEP_RSTART: begin
					emit(ACT_RSTART, '0, WAIT_NONE, 1'b1);
					step = step + 1;
				end
				STEP_LINE_0: send_char(0, STEP_LINE_2);
				STEP_LINE_2: send_char(2, STEP_RSTART);
				STEP_LINE_1: send_char(1, STEP_LINE_3);
				STEP_LINE_3: send_char(3, STEP_STOP);
				STEP_STOP: begin
					emit(ACT_STOP, '0, WAIT_NONE, 1'b1);
					step = STEP_IDLE;
				end
				default: step = STEP_IDLE;
			endcase
		end
	endfunction

	function automatic void take_request(cmd_t c, logic [7:0] status, logic [1:0] line,
		logic [4:0] col, logic [7:0] ch);
		logic [7:0] masked;
		masked = status & STAT_MASK;
		case (c)
			CMD_TICK: begin
				char_idx = 0;
				emit(ACT_START, '0, WAIT_NONE, 1'b1);
				step = STEP_ADDR;
			end
			CMD_STATUS: begin
				if (masked inside {STAT_START, STAT_RSTART, STAT_ADDR_ACK, STAT_DATA_ACK})
					advance_sequence();
			end
			CMD_INIT: begin
				char_idx = 0;
				step = STEP_INIT_FIRST;
				advance_sequence();
			end
			default: begin
				if (col < LINE_LEN)
					screen[int'(line)*LINE_LEN + int'(col)] = ch;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_byte = SLAVE_ADDR_RST;
			step = STEP_IDLE;
			char_idx = 0;
			foreach (screen[i])
				screen[i] = SPACE_CHAR;
			ops_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (ops_due.size() == 0) begin
					$error("bus action %0d with data %0h arrived with nothing expected",
						rsp.action, rsp.data_byte);
					fail_count++;
				end else begin
					want = ops_due.pop_front();
					if (rsp.action !== want.act) begin
						$error("action: expected %0d, got %0d", want.act, rsp.action);
						fail_count++;
					end
					if (rsp.data_byte !== want.data) begin
						$error("data_byte: expected %0h, got %0h", want.data, rsp.data_byte);
						fail_count++;
					end
					if (rsp.wait_before !== want.dly) begin
						$error("wait_before: expected %0d, got %0d", want.dly, rsp.wait_before);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				addr_byte = cfg_wdata;
			if (req.valid && req.ready)
				take_request(cmd_t'(req.cmd), req.bus_status, req.line_select, req.column,
					req.char_code);
		end
		pending = ops_due.size();
	end

endmodule

// File: tb/i2c_lcd_refresh_sequencer_unit_tb.sv
module i2c_lcd_refresh_sequencer_unit_tb;
	import lcdr_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	bit calm;
	int fail_count;
	int pending;
	int n_sent;

	lcdr_req_if req();
	lcdr_rsp_if rsp();

	i2c_lcd_refresh_sequencer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	lcdr_action_check i_action_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp.ready <= calm || ($urandom_range(99) >= 13);
	end

	task automatic issue(cmd_t c, logic [7:0] status, logic [1:0] line, logic [4:0] col,
		logic [7:0] ch);
		while (!calm && $urandom_range(99) < 13) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.cmd = c;
		req.bus_status = status;
		req.line_select = line;
		req.column = col;
		req.char_code = ch;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	function automatic logic [7:0] good_status();
		logic [7:0] s;
		case ($urandom_range(3))
			0: s = STAT_START;
			1: s = STAT_RSTART;
			2: s = STAT_ADDR_ACK;
			default: s = STAT_DATA_ACK;
		endcase
		return s | 8'($urandom_range(7));
	endfunction

	function automatic logic [7:0] bad_status();
		logic [7:0] s;
		do
			s = 8'($urandom);
		while ((s & STAT_MASK) inside {STAT_START, STAT_RSTART, STAT_ADDR_ACK, STAT_DATA_ACK});
		return s;
	endfunction

	function automatic logic [4:0] any_column();
		return ($urandom_range(99) < 85) ? 5'($urandom_range(19)) : 5'($urandom_range(31, 20));
	endfunction

	task automatic issue_write();
		issue(CMD_WRITE, 8'($urandom), 2'($urandom), any_column(), 8'($urandom));
	endtask

	task automatic issue_status(logic [7:0] s);
		issue(CMD_STATUS, s, 2'($urandom), 5'($urandom), 8'($urandom));
	endtask

	task automatic run_sequence(cmd_t opener, int goods);
		int done;
		int r;
		done = 0;
		issue(opener, 8'($urandom), 2'($urandom), 5'($urandom), 8'($urandom));
		while (done < goods) begin
			r = $urandom_range(99);
			if (r < 6) begin
				issue_status(bad_status());
			end else if (r < 10) begin
				issue_write();
			end else begin
				issue_status(good_status());
				done++;
			end
		end
	endtask

	task automatic settle();
		int k;
		req.valid = 1'b0;
		k = 0;
		while (pending != 0 && k < 5000) begin
			@(negedge clk);
			k++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_address(logic [7:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [7:0] addr_values [5];
		int target;
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		n_sent = 0;
		req.valid = 1'b0;
		req.cmd = CMD_TICK;
		req.bus_status = '0;
		req.line_select = '0;
		req.column = '0;
		req.char_code = '0;
		rsp.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		issue(CMD_STATUS, STAT_START, 2'd0, 5'd0, 8'h00);
		issue(CMD_WRITE, 8'h00, 2'd0, 5'd0, 8'h00);
		issue(CMD_WRITE, 8'hFF, 2'd3, 5'd19, 8'hFF);
		issue(CMD_WRITE, 8'h00, 2'd2, 5'd20, 8'h55);
		issue(CMD_WRITE, 8'h00, 2'd1, 5'd31, 8'hAA);
		issue(CMD_WRITE, 8'h00, 2'd1, 5'd19, 8'h7E);
		issue(CMD_INIT, 8'hFF, 2'd3, 5'd31, 8'hFF);
		issue_status(8'h0F);
		issue_status(8'h20);
		issue_status(8'h00);
		issue_status(8'hFF);
		issue_status(8'h13);
		issue_status(8'h1C);
		issue_status(8'h2A);
		issue(CMD_TICK, 8'h00, 2'd0, 5'd0, 8'h00);
		issue_status(STAT_ADDR_ACK);
		issue_status(STAT_DATA_ACK);
		issue(CMD_INIT, 8'h00, 2'd0, 5'd0, 8'h00);
		issue_status(STAT_RSTART);
		issue(CMD_WRITE, 8'h00, 2'd2, 5'd10, 8'h41);
		settle();

		addr_values = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), SLAVE_ADDR_RST};
		foreach (addr_values[p]) begin
			set_address(addr_values[p]);
			calm = (p == 2);
			target = n_sent + 320;
			while (n_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					run_sequence(CMD_TICK, ($urandom_range(9) == 0) ? $urandom_range(89) : 92);
				end else if (pick < 65) begin
					run_sequence(CMD_INIT, ($urandom_range(9) == 0) ? $urandom_range(15) : 17);
				end else if (pick < 85) begin
					repeat ($urandom_range(12, 1))
						issue_write();
				end else begin
					repeat ($urandom_range(6, 1))
						issue(cmd_t'($urandom_range(3)), 8'($urandom), 2'($urandom),
							5'($urandom), 8'($urandom));
				end
			end
			calm = 1'b0;
			settle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#4800000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
src/lcdr_pkg.sv
src/lcdr_if.sv
src/lcdr_ram.sv
src/lcdr_front.sv
src/lcdr_queue.sv
src/lcdr_back.sv
src/i2c_lcd_refresh_sequencer_unit.sv
tb/lcdr_action_check.sv
tb/i2c_lcd_refresh_sequencer_unit_tb.sv
